FILE: rtl/flb_pkg.sv
// shared constants, types and helpers of the flashed led light filter bank
`default_nettype none

package flb_pkg;

    // block configuration
    localparam int CHANNELS  = 5;
    localparam int FRAC_BITS = 16;
    localparam int N_ALPHA   = 5;

    // field widths
    localparam int ADC_W       = 10;
    localparam int TIME_W      = 32;
    localparam int HALF_W      = 16;
    localparam int ALPHA_W     = 17;
    localparam int ALPHA_FRAC  = 16;
    localparam int CHAN_W      = 3;
    localparam int OUT_LEVEL_W = 27;
    localparam int IDX_W       = 3;
    localparam int LEVEL_W     = 11 + FRAC_BITS;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // smoother bank storage: one wide word per led state
    localparam int BANKS  = 2;
    localparam int BANK_W = 1;
    localparam logic [BANK_W-1:0] BANK_OFF = 1'b0;
    localparam logic [BANK_W-1:0] BANK_ON  = 1'b1;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_HALF   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_ALPHA0 = 3'd1;

    // reset values and fixed-point constants
    localparam logic [HALF_W-1:0]  HALF_RESET = 16'd1000;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'h10000;
    localparam logic [10:0]        FULL_SCALE = 11'd1024;
    localparam logic [LEVEL_W-1:0] RESET_LEVEL =
        {{(LEVEL_W-9){1'b0}}, 9'd317} << FRAC_BITS;

    typedef logic [CHANNELS-1:0][LEVEL_W-1:0] t_levels;
    typedef logic [N_ALPHA-1:0][ALPHA_W-1:0]  t_alphas;

    // timing decision for one accepted sample
    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic              led;
        logic              report;
    } t_phase;

    // finished item handed to the output stage
    typedef struct packed {
        logic    led;
        logic    report;
        t_levels on_lvl;
        t_levels off_lvl;
    } t_item;

    // fit an internal level into the output field
    function automatic logic [OUT_LEVEL_W-1:0] to_out_level(input logic [LEVEL_W-1:0] v);
        logic [LEVEL_W+OUT_LEVEL_W-1:0] wide;
        wide = {{OUT_LEVEL_W{1'b0}}, v};
        return wide[OUT_LEVEL_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/flb_in_if.sv
// sample input channel: valid, ready and sample payload
`default_nettype none

interface flb_in_if import flb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADC_W-1:0]  adc_sample;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output adc_sample, output now_ms, input ready);
    modport sink   (input valid, input adc_sample, input now_ms, output ready);
endinterface

`default_nettype wire

FILE: rtl/flb_out_if.sv
// result output channel: valid, ready and result payload
`default_nettype none

interface flb_out_if import flb_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   led_on;
    logic                   is_report;
    logic [CHAN_W-1:0]      channel;
    logic [OUT_LEVEL_W-1:0] on_level;
    logic [OUT_LEVEL_W-1:0] off_level;
    logic                   last;

    modport source (output valid, output led_on, output is_report, output channel,
                    output on_level, output off_level, output last, input ready);
    modport sink   (input valid, input led_on, input is_report, input channel,
                    input on_level, input off_level, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/flashed_led_light_filter_bank.sv
// flashed led light filter bank: smoother banks in ram, led timing, result output
//
// Usage:
//   i_in carries one light sample (adc_sample) and its millisecond time (now_ms)
//   per beat; o_out carries results. A status beat (is_report 0, last 1) follows
//   every sample; a sample that closes a flash period yields one report beat per
//   channel instead, channel 0 upward, last set on the final one.
//   The two smoother banks (led off, led on) sit in one two-entry ram whose word holds
//   all channels: the bank is read when a sample is accepted, updated by the
//   channel multipliers in the update stage and written back when that stage advances,
//   with the write forwarded to a sample read in that same cycle.
//   A sample passes the update stage register, then the output register.
//   Throughput: one sample per cycle while results are taken; a report
//   occupies the output register until its final beat is taken, during
//   which at most one further sample enters.
//   Receiver stall: the output register holds its beat, the update stage
//   fills behind it and i_in.ready drops.
//   Reset: led off, period start 0, registers at their defaults; both banks
//   read as level 317 through per-bank valid bits, so no clearing pass runs.
//   Configuration writes are taken at any edge with i_cfg_we high.
`default_nettype none

module flashed_led_light_filter_bank import flb_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    flb_in_if.sink                  i_in,
    flb_out_if.source               o_out,
    input  wire logic               i_cfg_we,
    input  wire logic [IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ALPHA_W-1:0] i_cfg_data
);
    typedef enum logic [1:0] {
        SRC_RAM,
        SRC_FWD,
        SRC_RST
    } t_src;

    // configuration registers
    logic [HALF_W-1:0] r_half;
    t_alphas           r_alpha;
    logic [ALPHA_W-1:0] cfg_weight;

    // bank valid bits
    logic [BANKS-1:0] r_vld;

    // update stage
    logic              r_s1_valid;
    logic [BANK_W-1:0] r_s1_bank;
    logic              r_s1_led;
    logic              r_s1_report;
    logic [LEVEL_W-1:0] r_s1_x;
    t_src              r_s1_src_a;
    t_src              r_s1_src_b;
    t_levels           r_s1_fwd;

    logic              in_acc;
    logic              s1_adv;
    logic              ser_free;
    t_phase            phase;
    logic [BANK_W-1:0] bank_a;
    logic [BANK_W-1:0] bank_b;
    logic [10:0]       inv;
    logic [LEVEL_W-1:0] x;
    t_src              src_a;
    t_src              src_b;
    t_levels           ram_a;
    t_levels           ram_b;
    t_levels           prev_a;
    t_levels           prev_b;
    t_levels           s1_next;
    t_item             item;

    // alpha saturates at unity
    assign cfg_weight = (i_cfg_data > ALPHA_ONE) ? ALPHA_ONE : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= HALF_RESET;
            r_alpha <= {N_ALPHA{ALPHA_ONE}};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HALF: begin
                    r_half <= i_cfg_data[HALF_W-1:0];
                end
                default: begin
                    for (int k = 0; k < N_ALPHA; k++) begin
                        if (i_cfg_idx == IDX_W'(CFG_ALPHA0 + k)) begin
                            r_alpha[k] <= cfg_weight;
                        end
                    end
                end
            endcase
        end
    end

    // input handshake
    assign s1_adv     = r_s1_valid && ser_free;
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;

    flb_phase u_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (in_acc),
        .i_now_ms (i_in.now_ms),
        .i_half   (r_half),
        .o_phase  (phase)
    );

    // inverted sample in level format
    assign inv    = FULL_SCALE - {1'b0, i_in.adc_sample};
    assign x      = {inv, {FRAC_BITS{1'b0}}};
    assign bank_a = phase.bank;
    assign bank_b = ~phase.bank;

    // source of each bank word: forwarded write, ram or reset level
    always_comb begin
        if (s1_adv && (r_s1_bank == bank_a)) begin
            src_a = SRC_FWD;
        end else if (r_vld[bank_a]) begin
            src_a = SRC_RAM;
        end else begin
            src_a = SRC_RST;
        end
        if (s1_adv && (r_s1_bank == bank_b)) begin
            src_b = SRC_FWD;
        end else if (r_vld[bank_b]) begin
            src_b = SRC_RAM;
        end else begin
            src_b = SRC_RST;
        end
    end

    flb_ram #(
        .WIDTH (CHANNELS * LEVEL_W),
        .DEPTH (BANKS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (s1_adv),
        .i_waddr   (r_s1_bank),
        .i_wdata   (s1_next),
        .i_re      (in_acc),
        .i_raddr_a (bank_a),
        .i_raddr_b (bank_b),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    // update stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_vld      <= '0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_vld[r_s1_bank] <= 1'b1;
            end
        end
    end

    // update stage payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_bank   <= bank_a;
            r_s1_led    <= phase.led;
            r_s1_report <= phase.report;
            r_s1_x      <= x;
            r_s1_src_a  <= src_a;
            r_s1_src_b  <= src_b;
            r_s1_fwd    <= s1_next;
        end
    end

    // previous levels of both banks
    always_comb begin
        case (r_s1_src_a)
            SRC_RAM: prev_a = ram_a;
            SRC_FWD: prev_a = r_s1_fwd;
            default: prev_a = {CHANNELS{RESET_LEVEL}};
        endcase
        case (r_s1_src_b)
            SRC_RAM: prev_b = ram_b;
            SRC_FWD: prev_b = r_s1_fwd;
            default: prev_b = {CHANNELS{RESET_LEVEL}};
        endcase
    end

    flb_lanes u_lanes (
        .i_prev  (prev_a),
        .i_x     (r_s1_x),
        .i_alpha (r_alpha),
        .o_next  (s1_next)
    );

    // finished item
    always_comb begin
        item.led     = r_s1_led;
        item.report  = r_s1_report;
        item.on_lvl  = (r_s1_bank == BANK_ON) ? s1_next : prev_b;
        item.off_lvl = (r_s1_bank == BANK_ON) ? prev_b : s1_next;
    end

    flb_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_adv),
        .i_item  (item),
        .o_free  (ser_free),
        .o_out   (o_out)
    );

`ifndef SYNTH
    // a read that meets a write-back must take the forwarded word
    a_forward_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s1_adv |=> r_s1_src_a == SRC_FWD || r_s1_src_b == SRC_FWD)
        else $error("write-back not forwarded to overlapping read");
`endif
endmodule

`default_nettype wire

FILE: rtl/flb_ram.sv
// generic ram: one write port, two registered read ports
`default_nettype none

module flb_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 2,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [AW-1:0]          i_waddr,
    input  wire logic [WIDTH-1:0]       i_wdata,
    input  wire logic                   i_re,
    input  wire logic [AW-1:0]          i_raddr_a,
    input  wire logic [AW-1:0]          i_raddr_b,
    output logic      [WIDTH-1:0]       o_rdata_a,
    output logic      [WIDTH-1:0]       o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, old data on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

`default_nettype wire

FILE: rtl/flb_phase.sv
// led flash timing: period start, led state and report decision
`default_nettype none

module flb_phase import flb_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_acc,
    input  wire logic [TIME_W-1:0] i_now_ms,
    input  wire logic [HALF_W-1:0] i_half,
    output t_phase                 o_phase
);
    logic              r_led;
    logic [TIME_W-1:0] r_period_start;

    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] half_ext;
    logic [TIME_W-1:0] twice;
    logic              turned_on;
    logic              report;

    // elapsed time wraps with the timestamp
    always_comb begin
        elapsed   = i_now_ms - r_period_start;
        half_ext  = {{(TIME_W-HALF_W){1'b0}}, i_half};
        twice     = {{(TIME_W-HALF_W-1){1'b0}}, i_half, 1'b0};
        turned_on = r_led || (elapsed > half_ext);
        report    = turned_on && (elapsed > twice);
    end

    assign o_phase.bank   = r_led ? BANK_ON : BANK_OFF;
    assign o_phase.led    = report ? 1'b0 : turned_on;
    assign o_phase.report = report;

    // advance on each accepted sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led          <= 1'b0;
            r_period_start <= '0;
        end else if (i_acc) begin
            r_led <= report ? 1'b0 : turned_on;
            if (report) begin
                r_period_start <= r_period_start + twice;
            end
        end
    end

`ifndef SYNTH
    // a finished period always leaves the led dark
    a_report_led_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && report |=> !r_led)
        else $error("led still lit after report");
`endif
endmodule

`default_nettype wire

FILE: rtl/flb_lanes.sv
// smoother lanes: one exponential smoothing step per channel
`default_nettype none

module flb_lanes import flb_pkg::*; (
    input  wire t_levels              i_prev,
    input  wire logic [LEVEL_W-1:0]   i_x,
    input  wire t_alphas              i_alpha,
    output t_levels                   o_next
);
    // level' = prev + floor(alpha * (x - prev) / 2^16)
    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        logic        [ALPHA_W-1:0]         weight;
        logic signed [LEVEL_W:0]           diff;
        logic signed [LEVEL_W+ALPHA_W+1:0] prod;
        logic signed [LEVEL_W+ALPHA_W+1:0] shifted;
        logic signed [LEVEL_W+1:0]         sum;

        if (c < N_ALPHA) begin : g_reg_weight
            assign weight = i_alpha[c];
        end else begin : g_unit_weight
            assign weight = ALPHA_ONE;
        end

        always_comb begin
            diff    = $signed({1'b0, i_x}) - $signed({1'b0, i_prev[c]});
            prod    = $signed({1'b0, weight}) * diff;
            shifted = prod >>> ALPHA_FRAC;
            sum     = $signed({2'b00, i_prev[c]}) + shifted[LEVEL_W+1:0];
        end

        assign o_next[c] = sum[LEVEL_W-1:0];
    end
endmodule

`default_nettype wire

FILE: rtl/flb_ser.sv
// output stage: holds one finished item and plays out its beats
`default_nettype none

module flb_ser import flb_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_load,
    input  wire t_item  i_item,
    output logic        o_free,
    flb_out_if.source   o_out
);
    localparam logic [CH_W-1:0] CNT_LAST = CH_W'(CHANNELS - 1);

    logic            r_valid;
    logic [CH_W-1:0] r_cnt;
    t_item           r_item;

    logic            is_last;
    logic [CH_W+CHAN_W-1:0] chan_wide;

    assign is_last   = !r_item.report || (r_cnt == CNT_LAST);
    assign o_free    = !r_valid || (o_out.ready && is_last);
    assign chan_wide = {{CHAN_W{1'b0}}, r_cnt};

    // beat fields
    assign o_out.valid     = r_valid;
    assign o_out.led_on    = r_item.led;
    assign o_out.is_report = r_item.report;
    assign o_out.channel   = r_item.report ? chan_wide[CHAN_W-1:0] : '0;
    assign o_out.on_level  = r_item.report ? to_out_level(r_item.on_lvl[r_cnt]) : '0;
    assign o_out.off_level = r_item.report ? to_out_level(r_item.off_lvl[r_cnt]) : '0;
    assign o_out.last      = is_last;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_cnt   <= '0;
        end else if (r_valid && o_out.ready) begin
            if (is_last) begin
                r_valid <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
    end

`ifndef SYNTH
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("item loaded over a pending beat");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_cnt <= CNT_LAST)
        else $error("report channel counter out of range");
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_item.report |-> r_cnt == '0)
        else $error("status item past its only beat");
`endif
endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps
// self-checking bench for the flashed led light filter bank with its own smoother model

module tb;
    import flb_pkg::*;

    // one result beat as seen on the output channel
    typedef struct packed {
        logic                   led;
        logic                   report;
        logic [CHAN_W-1:0]      chan;
        logic [OUT_LEVEL_W-1:0] on_lvl;
        logic [OUT_LEVEL_W-1:0] off_lvl;
        logic                   last;
    } t_beat;

    // one light sample with its timestamp
    typedef struct packed {
        logic [ADC_W-1:0]  adc;
        logic [TIME_W-1:0] now;
    } t_sample;

    localparam int STALL_LIMIT       = 4000;
    localparam int TAIL_CYCLES       = 8;
    localparam int SAMPLES_PER_PHASE = 54;
    localparam int RANDOM_PHASES     = 5;

    // indexes past the last alpha register, writes there are dropped
    localparam logic [IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] CFG_SPARE_B = 3'd7;

    // led timing and smoother bank model plus the queue of beats still due
    class smoother_scoreboard;
        logic [HALF_W-1:0]  half_ms;
        logic [ALPHA_W-1:0] alpha [N_ALPHA];
        logic               led_lit;
        logic [TIME_W-1:0]  period_start;
        logic [LEVEL_W-1:0] on_lvl [CHANNELS];
        logic [LEVEL_W-1:0] off_lvl [CHANNELS];
        t_beat              due_beats[$];
        int                 errors;
        int                 samples;
        int                 periods;
        int                 statuses;
        int                 reg_writes;

        function new();
            half_ms      = HALF_RESET;
            led_lit      = 1'b0;
            period_start = '0;
            for (int c = 0; c < N_ALPHA; c++)
                alpha[c] = ALPHA_ONE;
            for (int c = 0; c < CHANNELS; c++) begin
                on_lvl[c]  = RESET_LEVEL;
                off_lvl[c] = RESET_LEVEL;
            end
            errors     = 0;
            samples    = 0;
            periods    = 0;
            statuses   = 0;
            reg_writes = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [ALPHA_W-1:0] data);
            reg_writes++;
            if (idx == CFG_HALF)
                half_ms = data[HALF_W-1:0];
            else if (idx >= CFG_ALPHA0 && idx < CFG_ALPHA0 + N_ALPHA)
                alpha[idx - CFG_ALPHA0] = data;
        endfunction

        // weight of a channel, saturated at one
        function logic [ALPHA_W-1:0] weight(int c);
            if (c >= N_ALPHA || alpha[c] > ALPHA_ONE)
                return ALPHA_ONE;
            return alpha[c];
        endfunction

        // truncated exponential smoothing step
        function logic [LEVEL_W-1:0] blend_level(logic [LEVEL_W-1:0] x,
                                                 logic [LEVEL_W-1:0] prev,
                                                 logic [ALPHA_W-1:0] w);
            logic [63:0] acc;
            acc = 64'(w) * 64'(x) + 64'(ALPHA_ONE - w) * 64'(prev);
            return acc[ALPHA_FRAC +: LEVEL_W];
        endfunction

        function void take_sample(logic [ADC_W-1:0] adc, logic [TIME_W-1:0] now);
            logic [LEVEL_W-1:0] x;
            logic [TIME_W-1:0]  elapsed;
            logic [TIME_W-1:0]  twice;
            samples++;
            x     = LEVEL_W'(FULL_SCALE - adc) << FRAC_BITS;
            twice = TIME_W'(half_ms) << 1;
            // update the bank of the current led state
            for (int c = 0; c < CHANNELS; c++) begin
                if (led_lit)
                    on_lvl[c] = blend_level(x, on_lvl[c], weight(c));
                else
                    off_lvl[c] = blend_level(x, off_lvl[c], weight(c));
            end
            // led timing, both transitions may fall on one sample
            elapsed = now - period_start;
            if (elapsed > TIME_W'(half_ms) && !led_lit)
                led_lit = 1'b1;
            if (elapsed > twice && led_lit) begin
                period_start = period_start + twice;
                led_lit      = 1'b0;
                periods++;
                for (int c = 0; c < CHANNELS; c++)
                    due_beats.push_back('{1'b0, 1'b1, CHAN_W'(c), on_lvl[c], off_lvl[c],
                                          c == CHANNELS - 1});
            end else begin
                statuses++;
                due_beats.push_back('{led_lit, 1'b0, '0, '0, '0, 1'b1});
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_beat(t_beat got);
            t_beat want;
            if (due_beats.size() == 0) begin
                errors++;
                $display("%0t unexpected beat: expected none actual %h", $time, got);
                return;
            end
            want = due_beats.pop_front();
            compare_field("led_on", want.led, got.led);
            compare_field("is_report", want.report, got.report);
            compare_field("channel", want.chan, got.chan);
            compare_field("on_level", want.on_lvl, got.on_lvl);
            compare_field("off_level", want.off_lvl, got.off_lvl);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [IDX_W-1:0]   i_cfg_idx;
    logic [ALPHA_W-1:0] i_cfg_data;

    flb_in_if  in_ch ();
    flb_out_if out_ch ();

    smoother_scoreboard sb;
    t_sample            directed[$];
    int                 tx_idle_pct;
    int                 rx_idle_pct;

    flashed_led_light_filter_bank DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // result beat checker
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_beat('{out_ch.led_on, out_ch.is_report, out_ch.channel,
                            out_ch.on_level, out_ch.off_level, out_ch.last});
    end

    // watchdog on cycles without any beat or register write
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t timeout, %0d beats still due", $time, sb.due_beats.size());
        $display("tb failed");
        $finish;
    end

    // random sample: mostly times around the current flash period, some anywhere
    function automatic t_sample make_sample();
        t_sample           s;
        logic [TIME_W-1:0] half;
        logic [TIME_W-1:0] twice;
        int                pick;
        half  = TIME_W'(sb.half_ms);
        twice = half << 1;
        pick  = $urandom_range(0, 99);
        s.adc = ADC_W'($urandom_range(0, 1023));
        if (pick < 12) begin
            s.now = $urandom();
        end else if (pick < 24) begin
            case ($urandom_range(0, 3))
                0:       s.now = sb.period_start + half;
                1:       s.now = sb.period_start + half + 1;
                2:       s.now = sb.period_start + twice;
                default: s.now = sb.period_start + twice + 1;
            endcase
        end else begin
            s.now = sb.period_start + TIME_W'($urandom_range(0, 2 * int'(twice) + 2));
        end
        return s;
    endfunction

    function automatic logic [ALPHA_W-1:0] pick_alpha();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 17'd1;
            2:       return ALPHA_ONE - 1;
            3:       return ALPHA_ONE;
            default: return '1;
        endcase
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [ALPHA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_settings(input logic [HALF_W-1:0] half, input t_alphas alphas);
        write_reg(CFG_HALF, ALPHA_W'(half));
        for (int c = 0; c < N_ALPHA; c++)
            write_reg(CFG_ALPHA0 + IDX_W'(c), alphas[c]);
    endtask

    // sample sender, from the directed list or random
    task automatic send_samples(input int count, input bit from_list);
        int      sent;
        t_sample nxt;
        sent = 0;
        while (sent < count) begin
            @(posedge i_clk);
            if (in_ch.valid && in_ch.ready) begin
                sb.take_sample(in_ch.adc_sample, in_ch.now_ms);
                sent++;
            end
            if (sent >= count) begin
                in_ch.valid <= 1'b0;
            end else if (!in_ch.valid || in_ch.ready) begin
                if ($urandom_range(0, 99) < tx_idle_pct) begin
                    in_ch.valid <= 1'b0;
                end else begin
                    nxt = from_list ? directed.pop_front() : make_sample();
                    in_ch.valid      <= 1'b1;
                    in_ch.adc_sample <= nxt.adc;
                    in_ch.now_ms     <= nxt.now;
                end
            end
        end
    endtask

    task automatic wait_drain();
        while (sb.due_beats.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // main sequence
    initial begin
        logic [TIME_W-1:0] ps;
        t_alphas           weights;
        logic [HALF_W-1:0] half;

        in_ch.valid      = 1'b0;
        in_ch.adc_sample = '0;
        in_ch.now_ms     = '0;
        out_ch.ready     = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        i_rst_n          = 1'b0;
        tx_idle_pct      = 14;
        rx_idle_pct      = 76;
        sb               = new();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: field extremes, both led edges, report, wrapped time
        directed.push_back('{10'd0, 32'd0});
        directed.push_back('{10'd1023, 32'd1000});
        directed.push_back('{10'd512, 32'd1001});
        directed.push_back('{10'd1023, 32'd2000});
        directed.push_back('{10'd0, 32'd2001});
        directed.push_back('{10'd700, 32'd4001});
        directed.push_back('{10'd1, 32'hFFFF_FFFF});
        directed.push_back('{10'd300, 32'd5000});
        send_samples(directed.size(), 1'b1);
        wait_drain();

        // zero half period, zero weight, saturating weight, out-of-range indexes
        weights[0] = '0;
        weights[1] = '1;
        weights[2] = ALPHA_ONE;
        weights[3] = 17'd1;
        weights[4] = ALPHA_ONE - 1;
        load_settings('0, weights);
        write_reg(CFG_SPARE_A, ALPHA_W'($urandom()));
        write_reg(CFG_SPARE_B, ALPHA_W'($urandom()));
        ps = sb.period_start;
        directed.push_back('{10'd0, ps});
        directed.push_back('{10'd1023, ps + 1});
        directed.push_back('{10'd512, ps});
        directed.push_back('{10'd100, ps + 5});
        send_samples(directed.size(), 1'b1);
        wait_drain();

        // random phases over several settings
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin
                    half = 16'd1;
                    for (int c = 0; c < N_ALPHA; c++)
                        weights[c] = ALPHA_W'($urandom());
                end
                1: begin
                    half = HALF_W'($urandom_range(2, 40));
                    for (int c = 0; c < N_ALPHA; c++)
                        weights[c] = ALPHA_W'($urandom_range(0, ALPHA_ONE));
                end
                2: begin
                    half = '1;
                    for (int c = 0; c < N_ALPHA; c++)
                        weights[c] = ALPHA_W'($urandom());
                end
                3: begin
                    half = '0;
                    for (int c = 0; c < N_ALPHA; c++)
                        weights[c] = ALPHA_W'($urandom_range(0, ALPHA_ONE));
                end
                default: begin
                    half = HALF_W'($urandom_range(3, 20));
                    for (int c = 0; c < N_ALPHA; c++)
                        weights[c] = pick_alpha();
                end
            endcase
            if (p == 2) begin
                tx_idle_pct = 76;
                rx_idle_pct = 14;
            end else if (p == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            load_settings(half, weights);
            send_samples(SAMPLES_PER_PHASE, 1'b0);
            wait_drain();
        end

        $display("run covered %0d samples giving %0d finished periods and %0d status beats",
                 sb.samples, sb.periods, sb.statuses);
        $display("%0d register writes: half periods 0, 1 and 65535, weights 0 to saturated",
                 sb.reg_writes);
        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
